>>> rtl/impact_magnitude_ranker_defines.svh
// Assertion macros shared by the impact magnitude ranker RTL.
// Included by each module that carries concurrent assertions; needs no package.
`ifndef IMPACT_MAGNITUDE_RANKER_DEFINES_SVH
`define IMPACT_MAGNITUDE_RANKER_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define IMR_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define IMR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/imr_pkg.sv
// Shared types, widths and the magnitude function of the impact magnitude ranker.
// Used by imr_cell, imr_report and impact_magnitude_ranker; depends on nothing.
`default_nettype none

package imr_pkg;

    localparam int IMPACT_W          = 16;
    localparam int KEY_W             = 15;
    localparam int IDX_W             = 6;
    localparam int RANK_W            = 7;
    localparam int DEFAULT_MAX_ITEMS = 64;

    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [RANK_W-1:0] rank_t;

    localparam key_t KEY_SAT = {KEY_W{1'b1}};

    typedef struct packed {
        logic signed [IMPACT_W-1:0] low_impact;
        logic signed [IMPACT_W-1:0] high_impact;
        logic                       last_item;
    } imr_in_t;

    typedef struct packed {
        idx_t  item_index;
        rank_t item_rank;
        key_t  impact_key;
        logic  final_result;
        logic  items_dropped;
    } imr_out_t;

    typedef struct packed {
        logic valid;
        key_t key;
        idx_t index;
    } imr_entry_t;

    typedef struct packed {
        logic insert;
        logic drain;
        key_t new_key;
        idx_t new_index;
    } imr_cell_ctrl_t;

    typedef struct packed {
        logic  wr_en;
        idx_t  wr_addr;
        rank_t wr_rank;
        key_t  wr_key;
        logic  rd_run;
        rank_t rd_count;
        logic  dropped;
    } imr_rpt_ctrl_t;

    function automatic key_t mag_sat(input logic signed [IMPACT_W-1:0] v);
        logic [IMPACT_W-1:0] neg;
        neg = IMPACT_W'(~v) + IMPACT_W'(1);
        if (!v[IMPACT_W-1]) begin
            return v[KEY_W-1:0];
        end else if (neg[IMPACT_W-1]) begin
            return KEY_SAT;
        end else begin
            return neg[KEY_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/imr_cell.sv
// One cell of the sorting chain: holds one key and its arrival index.
// Uses imr_pkg types; instantiated in a row by impact_magnitude_ranker.
`default_nettype none
`include "impact_magnitude_ranker_defines.svh"

module imr_cell (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire imr_pkg::imr_cell_ctrl_t ctrl,
    input  wire imr_pkg::imr_entry_t     left_entry,
    input  wire logic                    left_stays,
    input  wire imr_pkg::imr_entry_t     right_entry,
    output imr_pkg::imr_entry_t          entry,
    output logic                         stays
);
    import imr_pkg::*;

    logic valid_reg, valid_next;
    key_t key_reg, key_next;
    idx_t index_reg, index_next;

    assign stays = valid_reg && (key_reg > ctrl.new_key);

    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        index_next = index_reg;
        if (ctrl.drain) begin
            valid_next = right_entry.valid;
            key_next   = right_entry.key;
            index_next = right_entry.index;
        end else if (ctrl.insert && !stays) begin
            if (left_stays) begin
                valid_next = 1'b1;
                key_next   = ctrl.new_key;
                index_next = ctrl.new_index;
            end else begin
                valid_next = left_entry.valid;
                key_next   = left_entry.key;
                index_next = left_entry.index;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        key_reg   <= key_next;
        index_reg <= index_next;
    end

    assign entry = '{valid: valid_reg, key: key_reg, index: index_reg};

    `IMR_ASSERT(a_chain_sorted, aclk, aresetn, (valid_reg && right_entry.valid) |-> (key_reg >= right_entry.key), "Sorting chain is out of order.")
    `IMR_ASSERT(a_chain_packed, aclk, aresetn, !valid_reg |-> !right_entry.valid, "Sorting chain has a gap.")

endmodule

`default_nettype wire

>>> rtl/imr_report.sv
// Report buffer: rank and key per arrival index, read out in arrival order.
// Uses imr_pkg types; written from the drained chain by impact_magnitude_ranker.
`default_nettype none
`include "impact_magnitude_ranker_defines.svh"

module imr_report #(
    parameter int MAX_ITEMS = imr_pkg::DEFAULT_MAX_ITEMS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire imr_pkg::imr_rpt_ctrl_t ctrl,
    output logic                        rd_done,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output imr_pkg::imr_out_t           m_data
);
    import imr_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);

    typedef struct packed {
        rank_t rank;
        key_t  key;
    } rpt_word_t;

    rpt_word_t mem [MAX_ITEMS];
    rpt_word_t rd_word_reg;

    rank_t    rd_ptr_reg, rd_ptr_next;
    logic     fetch_valid_reg, fetch_valid_next;
    idx_t     fetch_idx_reg;
    logic     fetch_final_reg;
    logic     fetch_drop_reg;
    logic     m_valid_reg, m_valid_next;
    imr_out_t m_data_reg;

    logic out_free;
    logic fetch_free;
    logic issue;

    assign out_free   = !m_valid_reg || m_ready;
    assign fetch_free = !fetch_valid_reg || out_free;
    assign issue      = ctrl.rd_run && (rd_ptr_reg != ctrl.rd_count) && fetch_free;
    assign rd_done    = ctrl.rd_run && (rd_ptr_reg == ctrl.rd_count) && !fetch_valid_reg;

    always_comb begin
        if (!ctrl.rd_run) begin
            rd_ptr_next = '0;
        end else if (issue) begin
            rd_ptr_next = rd_ptr_reg + RANK_W'(1);
        end else begin
            rd_ptr_next = rd_ptr_reg;
        end
        fetch_valid_next = issue || (fetch_valid_reg && !out_free);
        m_valid_next     = out_free ? fetch_valid_reg : 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[ctrl.wr_addr[AW-1:0]] <= '{rank: ctrl.wr_rank, key: ctrl.wr_key};
        end
        if (issue) begin
            rd_word_reg <= mem[rd_ptr_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg      <= '0;
            fetch_valid_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            rd_ptr_reg      <= rd_ptr_next;
            fetch_valid_reg <= fetch_valid_next;
            m_valid_reg     <= m_valid_next;
        end
        if (issue) begin
            fetch_idx_reg   <= rd_ptr_reg[IDX_W-1:0];
            fetch_final_reg <= (rd_ptr_reg + RANK_W'(1)) == ctrl.rd_count;
            fetch_drop_reg  <= ctrl.dropped;
        end
        if (out_free && fetch_valid_reg) begin
            m_data_reg <= '{item_index:    fetch_idx_reg,
                            item_rank:     rd_word_reg.rank,
                            impact_key:    rd_word_reg.key,
                            final_result:  fetch_final_reg,
                            items_dropped: fetch_drop_reg};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `IMR_ASSERT(a_rd_ptr_bound, aclk, aresetn, ctrl.rd_run |-> (rd_ptr_reg <= ctrl.rd_count), "Report read pointer ran past the item count.")

endmodule

`default_nettype wire

>>> rtl/impact_magnitude_ranker.sv
// Top level of the impact magnitude ranker: load control, sorting chain, report.
// Depends on imr_pkg, imr_cell and imr_report.
//
// Items enter one per cycle while the block is loading; each item's key is the larger
// saturated magnitude of its two impacts, and the keys settle into a row of MAX_ITEMS
// cells kept in descending order, a new key ahead of equal older ones. After the word
// marked last, s_ready stays low while the n stored entries drain out of the chain
// head, one per cycle, into the report memory, and then for the n result words, which
// leave one per cycle from the memory's single read port through a fetch register and
// an output register, slower under back-pressure. The drain also empties the chain, so a
// new set can follow at once. Words beyond MAX_ITEMS are dropped and flagged.
`default_nettype none
`include "impact_magnitude_ranker_defines.svh"

module impact_magnitude_ranker #(
    parameter int MAX_ITEMS = imr_pkg::DEFAULT_MAX_ITEMS
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire imr_pkg::imr_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output imr_pkg::imr_out_t     m_data
);
    import imr_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_FINISH,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t          state_reg, state_next;
    logic            s_ready_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic            overflow_reg, overflow_next;
    logic            pend_ins_reg;
    key_t            pend_key_reg;
    idx_t            pend_idx_reg;
    rank_t           drain_rank_reg, drain_rank_next;

    logic            accept;
    logic            room;
    logic            rpt_done;
    key_t            key_lo;
    key_t            key_hi;
    imr_cell_ctrl_t  cell_ctrl;
    imr_rpt_ctrl_t   rpt_ctrl;
    imr_entry_t      ent  [MAX_ITEMS];
    logic            stay [MAX_ITEMS];

    assign accept = s_valid && s_ready_reg;
    assign room   = count_reg < CNT_W'(MAX_ITEMS);
    assign key_lo = mag_sat(s_data.low_impact);
    assign key_hi = mag_sat(s_data.high_impact);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        overflow_next   = overflow_reg;
        drain_rank_next = drain_rank_reg;
        case (state_reg)
            ST_LOAD: begin
                if (accept) begin
                    if (room) begin
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        overflow_next = 1'b1;
                    end
                    if (s_data.last_item) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                state_next      = ST_DRAIN;
                drain_rank_next = RANK_W'(1);
            end
            ST_DRAIN: begin
                if (drain_rank_reg == RANK_W'(count_reg)) begin
                    state_next = ST_EMIT;
                end else begin
                    drain_rank_next = drain_rank_reg + RANK_W'(1);
                end
            end
            ST_EMIT: begin
                if (rpt_done) begin
                    state_next    = ST_LOAD;
                    count_next    = '0;
                    overflow_next = 1'b0;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            s_ready_reg  <= 1'b0;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            pend_ins_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s_ready_reg  <= (state_next == ST_LOAD);
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            pend_ins_reg <= accept && room;
        end
        drain_rank_reg <= drain_rank_next;
        if (accept) begin
            pend_key_reg <= (key_lo > key_hi) ? key_lo : key_hi;
            pend_idx_reg <= IDX_W'(count_reg);
        end
    end

    assign s_ready = s_ready_reg;

    assign cell_ctrl = '{insert:    pend_ins_reg,
                         drain:     (state_reg == ST_DRAIN),
                         new_key:   pend_key_reg,
                         new_index: pend_idx_reg};

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_chain
        imr_entry_t left_e;
        imr_entry_t right_e;
        logic       left_s;

        if (g == 0) begin : g_head
            assign left_e = '0;
            assign left_s = 1'b1;
        end else begin : g_body
            assign left_e = ent[g-1];
            assign left_s = stay[g-1];
        end

        if (g == MAX_ITEMS - 1) begin : g_tail
            assign right_e = '0;
        end else begin : g_next
            assign right_e = ent[g+1];
        end

        imr_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (cell_ctrl),
            .left_entry  (left_e),
            .left_stays  (left_s),
            .right_entry (right_e),
            .entry       (ent[g]),
            .stays       (stay[g])
        );
    end

    assign rpt_ctrl = '{wr_en:    (state_reg == ST_DRAIN),
                        wr_addr:  ent[0].index,
                        wr_rank:  drain_rank_reg,
                        wr_key:   ent[0].key,
                        rd_run:   (state_reg == ST_EMIT),
                        rd_count: RANK_W'(count_reg),
                        dropped:  overflow_reg};

    imr_report #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_report (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (rpt_ctrl),
        .rd_done (rpt_done),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    `IMR_ASSERT(a_drain_head_valid, aclk, aresetn, (state_reg == ST_DRAIN) |-> ent[0].valid, "Chain head is empty while draining.")
    `IMR_ASSERT_NEXT(a_drain_empties, aclk, aresetn, (state_reg == ST_DRAIN) && (drain_rank_reg == RANK_W'(count_reg)), !ent[0].valid, "Chain not empty after the drain.")
    `IMR_ASSERT(a_set_cleared, aclk, aresetn, (state_reg == ST_LOAD) && ($past(state_reg) == ST_EMIT) |-> ((count_reg == '0) && !overflow_reg), "Set state not cleared after the report.")

endmodule

`default_nettype wire
